### src/tans_pkg.sv
`default_nettype none

package tans_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int COORD_BITS  = 24;
    localparam int IDX_BITS    = 10;
    localparam int ELEM_BITS   = 16;
    localparam int VALUE_BITS  = 64;
    localparam int ADDR_BITS   = $clog2(NODE_COUNT);

    localparam int PROD_BITS   = 2 * COORD_BITS + 1;
    localparam int SUM_BITS    = 2 * COORD_BITS + 3;
    localparam int AREA_BITS   = SUM_BITS - 1;
    localparam int BIAS_BITS   = AREA_BITS + 2;

    // floor(area/3) by long division, one 16-bit digit a step
    localparam int DIGIT_BITS   = 16;
    localparam int DIV_DIGITS   = (BIAS_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DIV_BITS     = DIV_DIGITS * DIGIT_BITS;
    localparam int RECIP3_SHIFT = DIGIT_BITS + 3;
    localparam int RECIP3       = (2 ** RECIP3_SHIFT + 2) / 3;
    localparam logic [DIV_BITS-1:0] DIV_BIAS = DIV_BITS'(3) << (AREA_BITS - 1);

    localparam int QUEUE_BITS  = 2;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_BITS;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TRI  = 2'd1,
        REQ_READ = 2'd2
    } t_req;

    typedef struct packed {
        t_req                         req_type;
        logic [IDX_BITS-1:0]          node_index;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic [IDX_BITS-1:0]          vertex_a;
        logic [IDX_BITS-1:0]          vertex_b;
        logic [IDX_BITS-1:0]          vertex_c;
        logic [ELEM_BITS-1:0]         element_index;
    } t_in_word;

    typedef struct packed {
        t_req                         result_kind;
        logic [ELEM_BITS-1:0]         out_element;
        logic [IDX_BITS-1:0]          out_node;
        logic signed [VALUE_BITS-1:0] value;
        logic                         saturated;
    } t_out_word;

    typedef struct packed {
        t_req                           kind;
        logic [IDX_BITS-1:0]            node;
        logic [ELEM_BITS-1:0]           elem;
        logic signed [AREA_BITS-1:0]    area;
        logic signed [AREA_BITS-1:0]    share;
        logic [2:0][IDX_BITS-1:0]       verts;
    } t_job;

    function automatic logic node_ok(input logic [IDX_BITS-1:0] idx);
        return (32'(idx) < 32'(NODE_COUNT));
    endfunction

    function automatic logic [ADDR_BITS-1:0] node_addr(input logic [IDX_BITS-1:0] idx);
        return ADDR_BITS'(idx);
    endfunction

endpackage

`default_nettype wire

### src/tans_front.sv
`default_nettype none

module tans_front import tans_pkg::*; (
    input  var logic     i_clk,
    input  var logic     i_rst_n,
    input  var logic     i_valid,
    input  var t_in_word i_word,
    output logic         o_stall,
    input  var logic     i_hold,
    output logic         o_push,
    output t_job         o_job,
    input  var logic     i_full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_RD,
        F_MUL,
        F_DIV,
        F_PUSH
    } t_fstate;

    t_fstate                      r_state;
    logic [2:0]                   r_cnt;
    t_job                         r_job;
    logic signed [COORD_BITS-1:0] r_x [3];
    logic signed [COORD_BITS-1:0] r_y [3];
    logic signed [COORD_BITS-1:0] r_xd;
    logic signed [COORD_BITS-1:0] r_yd;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [SUM_BITS-1:0]   r_acc;
    logic [DIV_BITS-1:0]          r_u;
    logic [DIV_BITS-1:0]          r_q;
    logic [1:0]                   r_rem;

    logic signed [COORD_BITS-1:0] x_mem [NODE_COUNT];
    logic signed [COORD_BITS-1:0] y_mem [NODE_COUNT];

    logic                         accept;
    logic                         mem_we;
    logic [IDX_BITS-1:0]          rd_idx;
    logic [IDX_BITS-1:0]          cur_vert;
    logic signed [COORD_BITS:0]   diff;
    logic signed [PROD_BITS-1:0]  mul_w;
    logic signed [AREA_BITS-1:0]  area_w;
    logic [DIGIT_BITS+1:0]        div_v;
    logic [2*DIGIT_BITS+3:0]      div_p;
    logic [DIGIT_BITS-1:0]        div_qd;
    logic [DIGIT_BITS+1:0]        div_r;

    assign o_stall = (r_state != F_IDLE) || i_hold;
    assign accept  = i_valid && !o_stall;
    assign mem_we  = accept && (i_word.req_type == REQ_LOAD) && node_ok(i_word.node_index);

    always_comb begin
        if (r_state == F_IDLE) begin
            rd_idx = i_word.vertex_a;
        end else if (r_cnt == 3'd0) begin
            rd_idx = r_job.verts[1];
        end else begin
            rd_idx = r_job.verts[2];
        end
    end

    always_comb begin
        if (r_cnt == 3'd0) begin
            cur_vert = r_job.verts[0];
        end else if (r_cnt == 3'd1) begin
            cur_vert = r_job.verts[1];
        end else begin
            cur_vert = r_job.verts[2];
        end
    end

    // x0*(y1-y2), operands rotate each step
    assign diff   = (COORD_BITS+1)'(r_y[1]) - (COORD_BITS+1)'(r_y[2]);
    assign mul_w  = PROD_BITS'(r_x[0]) * PROD_BITS'(diff);
    assign area_w = r_acc[SUM_BITS-1:1];

    // one digit of the biased divide by three
    assign div_v  = {r_rem, r_u[DIV_BITS-1 -: DIGIT_BITS]};
    assign div_p  = (2*DIGIT_BITS+4)'(div_v) * (2*DIGIT_BITS+4)'(RECIP3);
    assign div_qd = div_p[RECIP3_SHIFT +: DIGIT_BITS];
    assign div_r  = div_v - ((DIGIT_BITS+2)'(div_qd) * (DIGIT_BITS+2)'(3));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            x_mem[node_addr(i_word.node_index)] <= i_word.coord_x;
            y_mem[node_addr(i_word.node_index)] <= i_word.coord_y;
        end
        r_xd <= x_mem[node_addr(rd_idx)];
        r_yd <= y_mem[node_addr(rd_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_job.kind  <= i_word.req_type;
                        r_job.node  <= i_word.node_index;
                        r_job.elem  <= i_word.element_index;
                        r_job.area  <= '0;
                        r_job.share <= '0;
                        r_job.verts <= {i_word.vertex_c, i_word.vertex_b, i_word.vertex_a};
                        r_cnt       <= '0;
                        unique case (i_word.req_type)
                            REQ_LOAD: r_state <= F_PUSH;
                            REQ_READ: r_state <= F_PUSH;
                            REQ_TRI:  r_state <= F_RD;
                            default:  r_state <= F_IDLE;
                        endcase
                    end
                end
                F_RD: begin
                    r_x[0] <= r_x[1];
                    r_x[1] <= r_x[2];
                    r_x[2] <= node_ok(cur_vert) ? r_xd : '0;
                    r_y[0] <= r_y[1];
                    r_y[1] <= r_y[2];
                    r_y[2] <= node_ok(cur_vert) ? r_yd : '0;
                    if (r_cnt == 3'd2) begin
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= F_MUL;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                F_MUL: begin
                    if (r_cnt < 3'd3) begin
                        r_prod <= mul_w;
                        r_x[0] <= r_x[1];
                        r_x[1] <= r_x[2];
                        r_x[2] <= r_x[0];
                        r_y[0] <= r_y[1];
                        r_y[1] <= r_y[2];
                        r_y[2] <= r_y[0];
                    end
                    if (r_cnt != 3'd0 && r_cnt != 3'd4) begin
                        r_acc <= r_acc + SUM_BITS'(r_prod);
                    end
                    if (r_cnt == 3'd4) begin
                        r_job.area <= area_w;
                        r_u        <= DIV_BITS'(area_w) + DIV_BIAS;
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_state    <= F_DIV;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                F_DIV: begin
                    r_u   <= r_u << DIGIT_BITS;
                    r_q   <= {r_q[DIV_BITS-DIGIT_BITS-1:0], div_qd};
                    r_rem <= div_r[1:0];
                    if (r_cnt == 3'(DIV_DIGITS - 1)) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_full;

    // quotient carries a bias of 2^(AREA_BITS-1): flip the top bit to remove it
    always_comb begin
        o_job       = r_job;
        o_job.share = {~r_q[AREA_BITS-1], r_q[AREA_BITS-2:0]};
    end

endmodule

`default_nettype wire

### src/tans_queue.sv
`default_nettype none

module tans_queue import tans_pkg::*; (
    input  var logic i_clk,
    input  var logic i_rst_n,
    input  var logic i_push,
    input  var t_job i_job,
    output logic     o_full,
    input  var logic i_pop,
    output logic     o_valid,
    output t_job     o_job
);

    t_job                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_BITS-1:0] r_wp;
    logic [QUEUE_BITS-1:0] r_rp;
    logic [QUEUE_BITS:0]   r_count;

    assign o_full  = (r_count == (QUEUE_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/tans_back.sv
`default_nettype none

module tans_back import tans_pkg::*; (
    input  var logic i_clk,
    input  var logic i_rst_n,
    input  var logic i_job_valid,
    input  var t_job i_job,
    output logic     o_pop,
    output logic     o_hold,
    output logic     o_valid,
    output t_out_word o_word,
    input  var logic i_stall
);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RDV,
        B_UPD,
        B_EMIT
    } t_bstate;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    t_bstate                      r_state;
    logic [ADDR_BITS-1:0]         r_clr;
    logic [1:0]                   r_cnt;
    t_job                         r_job;
    logic                         r_sat;
    logic signed [VALUE_BITS-1:0] r_rd;
    logic [ADDR_BITS-1:0]         r_rd_addr;
    logic                         r_fw_valid;
    logic [ADDR_BITS-1:0]         r_fw_addr;
    logic signed [VALUE_BITS-1:0] r_fw_data;
    t_out_word                    r_res;
    logic                         r_out_valid;
    t_out_word                    r_out;

    logic signed [VALUE_BITS-1:0] vol_mem [NODE_COUNT];

    logic                         we;
    logic [ADDR_BITS-1:0]         waddr;
    logic signed [VALUE_BITS-1:0] wdata;
    logic [IDX_BITS-1:0]          rd_idx;
    logic [IDX_BITS-1:0]          cur_vert;
    logic [IDX_BITS-1:0]          next_vert;
    logic signed [VALUE_BITS-1:0] cur;
    logic signed [VALUE_BITS-1:0] share_ext;
    logic signed [VALUE_BITS:0]   sum_w;
    logic                         ovf;
    logic signed [VALUE_BITS-1:0] upd_val;
    logic                         upd_sat;

    assign o_hold  = (r_state == B_CLEAR);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    assign cur_vert  = (r_cnt == 2'd0) ? r_job.verts[0] :
                       (r_cnt == 2'd1) ? r_job.verts[1] : r_job.verts[2];
    assign next_vert = (r_cnt == 2'd0) ? r_job.verts[1] : r_job.verts[2];

    // bypass the write of the cycle the read was issued in
    assign cur = (r_fw_valid && (r_fw_addr == r_rd_addr)) ? r_fw_data : r_rd;

    assign share_ext = VALUE_BITS'(r_job.share);
    assign sum_w     = (VALUE_BITS+1)'(cur) + (VALUE_BITS+1)'(share_ext);
    assign ovf       = (sum_w[VALUE_BITS] != sum_w[VALUE_BITS-1]);
    assign upd_val   = ovf ? (sum_w[VALUE_BITS] ? VAL_MIN : VAL_MAX) : sum_w[VALUE_BITS-1:0];
    assign upd_sat   = ovf && node_ok(cur_vert);

    always_comb begin
        we     = 1'b0;
        waddr  = r_clr;
        wdata  = '0;
        rd_idx = next_vert;
        o_pop  = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                we = 1'b1;
            end
            B_IDLE: begin
                rd_idx = (i_job.kind == REQ_TRI) ? i_job.verts[0] : i_job.node;
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    if (i_job.kind == REQ_LOAD) begin
                        we    = node_ok(i_job.node);
                        waddr = node_addr(i_job.node);
                    end
                end
            end
            B_UPD: begin
                we    = node_ok(cur_vert);
                waddr = node_addr(cur_vert);
                wdata = upd_val;
            end
            B_RDV, B_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            vol_mem[waddr] <= wdata;
        end
        r_rd      <= vol_mem[node_addr(rd_idx)];
        r_rd_addr <= node_addr(rd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fw_valid <= we;
            r_fw_addr  <= waddr;
            r_fw_data  <= wdata;
            if (r_state == B_EMIT && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_BITS'(NODE_COUNT - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job             <= i_job;
                        r_sat             <= 1'b0;
                        r_cnt             <= '0;
                        r_res.result_kind <= i_job.kind;
                        r_res.out_element <= '0;
                        r_res.out_node    <= i_job.node;
                        r_res.value       <= '0;
                        r_res.saturated   <= 1'b0;
                        unique case (i_job.kind)
                            REQ_LOAD: r_state <= B_EMIT;
                            REQ_READ: r_state <= B_RDV;
                            REQ_TRI:  r_state <= B_UPD;
                            default:  r_state <= B_IDLE;
                        endcase
                    end
                end
                B_RDV: begin
                    r_res.value <= node_ok(r_job.node) ? cur : '0;
                    r_state     <= B_EMIT;
                end
                B_UPD: begin
                    r_sat <= r_sat | upd_sat;
                    if (r_cnt == 2'd2) begin
                        r_res.out_element <= r_job.elem;
                        r_res.out_node    <= '0;
                        r_res.value       <= VALUE_BITS'(r_job.area);
                        r_res.saturated   <= r_sat | upd_sat;
                        r_state           <= B_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                B_EMIT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out   <= r_res;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/triangle_area_node_scatter.sv
// An input word passes the front sequencer, job queue, back end and output register.
// The front takes no new input word until it has pushed its last job; a triangle is paced
// by the front sequencer (3 coordinate reads, 3 multiplies, 4-digit divide by three).
// The back end does 3 read-modify-writes per triangle on the volume memory, one per cycle.
// Reset: synchronous, active low; all 1024 volume memory entries are then zeroed,
// with o_stall held high until the clear finishes. Coordinate memories are not cleared.
`default_nettype none

module triangle_area_node_scatter import tans_pkg::*; (
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_valid,
    output logic          o_stall,
    input  var t_in_word  i_word,
    output logic          o_valid,
    input  var logic      i_stall,
    output t_out_word     o_word
);

    logic push;
    logic pop;
    logic full;
    logic job_valid;
    logic hold;
    t_job front_job;
    t_job queue_job;

    tans_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_stall (o_stall),
        .i_hold  (hold),
        .o_push  (push),
        .o_job   (front_job),
        .i_full  (full)
    );

    tans_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (queue_job)
    );

    tans_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_hold      (hold),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_stall     (i_stall)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tans_pkg::*;

    localparam int     WORD_COUNT   = 1700;
    localparam int     HOT_NODES    = 16;
    localparam int     IN_BITS      = $bits(t_in_word);
    localparam int     CHECK_BITS   = VALUE_BITS + 1;
    localparam longint TIMEOUT_NS   = 16_000_000;
    localparam t_req   REQ_UNUSED   = t_req'(2'd3);
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VOLUME_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VOLUME_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef struct {
        t_in_word word;
        int       gap;
        bit       drain;
    } t_mesh_request;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_word  i_word  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_word;

    triangle_area_node_scatter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_mesh_request mesh_requests[$];
    t_out_word     result_due[$];
    bit            coord_known [NODE_COUNT];
    int            known_nodes[$];

    logic signed [COORD_BITS-1:0] mesh_x      [NODE_COUNT];
    logic signed [COORD_BITS-1:0] mesh_y      [NODE_COUNT];
    logic signed [VALUE_BITS-1:0] node_volume [NODE_COUNT];

    int mismatches   = 0;
    int results_owed = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    int long_holds   = 0;
    bit sent_all     = 1'b0;

    // area of the element and share scattered to each vertex, floored at every step
    function automatic bit scatter_area(input t_in_word w, output t_out_word r);
        logic [IDX_BITS-1:0]          v [3];
        logic signed [VALUE_BITS-1:0] px [3];
        logic signed [VALUE_BITS-1:0] py [3];
        logic signed [VALUE_BITS-1:0] twice, area, share, acc, nxt;
        logic                         sat;
        r = '0;
        r.result_kind = w.req_type;
        sat = 1'b0;
        case (w.req_type)
            REQ_LOAD: begin
                mesh_x[w.node_index] = w.coord_x;
                mesh_y[w.node_index] = w.coord_y;
                node_volume[w.node_index] = '0;
                r.out_node = w.node_index;
                return 1'b1;
            end
            REQ_READ: begin
                r.out_node = w.node_index;
                r.value = node_volume[w.node_index];
                return 1'b1;
            end
            REQ_TRI: begin
                v[0] = w.vertex_a;
                v[1] = w.vertex_b;
                v[2] = w.vertex_c;
                for (int k = 0; k < 3; k++) begin
                    px[k] = VALUE_BITS'(mesh_x[v[k]]);
                    py[k] = VALUE_BITS'(mesh_y[v[k]]);
                end
                twice = px[0] * py[1] - px[1] * py[0]
                      + px[1] * py[2] - px[2] * py[1]
                      + px[2] * py[0] - px[0] * py[2];
                area = twice >>> 1;
                share = area / 3;
                if (area % 3 != 0 && area < 0) begin
                    share = share - 1;
                end
                for (int k = 0; k < 3; k++) begin
                    acc = node_volume[v[k]];
                    nxt = acc + share;
                    if (share > 0 && nxt < acc) begin
                        nxt = VOLUME_MAX;
                        sat = 1'b1;
                    end else if (share < 0 && nxt > acc) begin
                        nxt = VOLUME_MIN;
                        sat = 1'b1;
                    end
                    node_volume[v[k]] = nxt;
                end
                r.out_element = w.element_index;
                r.value = area;
                r.saturated = sat;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_field(input string name, input logic signed [64:0] want,
                                input logic signed [64:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    function automatic t_in_word scrambled_word(input t_req kind);
        t_in_word w;
        w = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        w.req_type = kind;
        return w;
    endfunction

    task automatic queue_word(input t_in_word w, input int gap, input bit drain);
        t_mesh_request m;
        m.word = w;
        m.gap = gap;
        m.drain = drain;
        mesh_requests.push_back(m);
        if (w.req_type == REQ_LOAD && !coord_known[w.node_index]) begin
            coord_known[w.node_index] = 1'b1;
            known_nodes.push_back(int'(w.node_index));
        end
    endtask

    task automatic load_node(input int idx, input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y);
        t_in_word w;
        w = scrambled_word(REQ_LOAD);
        w.node_index = IDX_BITS'(idx);
        w.coord_x = x;
        w.coord_y = y;
        queue_word(w, 0, 1'b0);
    endtask

    task automatic triangle(input int a, input int b, input int c, input int elem);
        t_in_word w;
        w = scrambled_word(REQ_TRI);
        w.vertex_a = IDX_BITS'(a);
        w.vertex_b = IDX_BITS'(b);
        w.vertex_c = IDX_BITS'(c);
        w.element_index = ELEM_BITS'(elem);
        queue_word(w, 0, 1'b0);
    endtask

    task automatic read_node(input int idx);
        t_in_word w;
        w = scrambled_word(REQ_READ);
        w.node_index = IDX_BITS'(idx);
        queue_word(w, 0, 1'b0);
    endtask

    // vertices only ever name nodes whose coordinates were loaded
    function automatic logic [IDX_BITS-1:0] known_vertex();
        int n;
        if ($urandom_range(0, 99) < 60) begin
            do n = $urandom_range(0, HOT_NODES - 1); while (!coord_known[n]);
            return IDX_BITS'(n);
        end
        return IDX_BITS'(known_nodes[$urandom_range(0, known_nodes.size() - 1)]);
    endfunction

    function automatic logic [IDX_BITS-1:0] any_node();
        if ($urandom_range(0, 99) < 60) begin
            return IDX_BITS'($urandom_range(0, HOT_NODES - 1));
        end
        return IDX_BITS'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    function automatic logic signed [COORD_BITS-1:0] random_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return COORD_BITS'($urandom);
        end else if (pick < 90) begin
            return COORD_BITS'($urandom_range(0, 32767) - 16384);
        end else if (pick < 95) begin
            return COORD_MAX;
        end
        return COORD_MIN;
    endfunction

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 88) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    initial begin
        t_in_word w;
        int       made;
        int       roll;

        load_node(0, COORD_MIN, COORD_MIN);
        load_node(1, COORD_MAX, COORD_MIN);
        load_node(2, COORD_MIN, COORD_MAX);
        load_node(1023, COORD_MAX, COORD_MAX);
        load_node(3, '0, '0);
        load_node(4, COORD_BITS'(1), '0);
        load_node(5, '0, COORD_BITS'(1));
        triangle(0, 1, 2, 0);
        triangle(0, 2, 1, 65535);
        triangle(1, 1023, 2, 1);
        triangle(0, 0, 1, 2);
        triangle(3, 4, 5, 3);
        triangle(3, 5, 4, 4);
        triangle(1023, 1023, 1023, 5);
        read_node(0);
        read_node(1);
        read_node(2);
        read_node(1023);
        read_node(4);
        read_node(512);
        queue_word(scrambled_word(REQ_UNUSED), 0, 1'b0);
        load_node(0, COORD_MIN, COORD_MAX);
        read_node(0);

        made = 0;
        while (made < WORD_COUNT) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                w = scrambled_word(REQ_LOAD);
                w.node_index = any_node();
                w.coord_x = random_coord();
                w.coord_y = random_coord();
            end else if (roll < 65) begin
                w = scrambled_word(REQ_TRI);
                w.vertex_a = known_vertex();
                w.vertex_b = known_vertex();
                w.vertex_c = known_vertex();
            end else if (roll < 95) begin
                w = scrambled_word(REQ_READ);
                w.node_index = any_node();
            end else begin
                w = scrambled_word(REQ_UNUSED);
            end
            queue_word(w, (made >= 600 && made < 800) ? 0 : idle_gap(),
                       made == 0 || made == 1200 || $urandom_range(0, 99) == 0);
            if (w.req_type != REQ_UNUSED) begin
                made++;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(sent_all && results_owed == 0)) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        if (result_due.size() != 0) begin
            $error("%0d results never arrived", result_due.size());
        end
        if (mismatches == 0 && result_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $error("timeout with %0d results outstanding", result_due.size());
        $display("FAILURE");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        logic fetch;
        logic launched;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            idle_cycles = 0;
            sent_all <= 1'b0;
        end else begin
            fetch = !i_valid || !o_stall;
            launched = 1'b0;
            if (fetch) begin
                if (mesh_requests.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (mesh_requests[0].drain && (i_valid || results_owed != 0)) begin
                    i_valid <= 1'b0;
                end else if (idle_cycles < mesh_requests[0].gap) begin
                    idle_cycles++;
                    i_valid <= 1'b0;
                end else begin
                    i_word <= mesh_requests[0].word;
                    i_valid <= 1'b1;
                    idle_cycles = 0;
                    launched = 1'b1;
                    void'(mesh_requests.pop_front());
                end
            end
            sent_all <= fetch && !launched && mesh_requests.size() == 0;
        end
    end

    // receiver stall: random stretches plus two long hold-offs to fill the block
    always @(posedge i_clk) begin
        int pick;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left <= 0;
            long_holds <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (long_holds < 2 && results_seen >= 300 + 700 * long_holds) begin
            i_stall <= 1'b1;
            hold_left <= 400;
            long_holds <= long_holds + 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                i_stall <= 1'b0;
                hold_left <= $urandom_range(20, 60);
            end else if (pick < 55) begin
                i_stall <= 1'b0;
                hold_left <= $urandom_range(0, 8);
            end else if (pick < 88) begin
                i_stall <= 1'b1;
                hold_left <= $urandom_range(0, 3);
            end else if (pick < 98) begin
                i_stall <= 1'b1;
                hold_left <= $urandom_range(4, 15);
            end else begin
                i_stall <= 1'b1;
                hold_left <= $urandom_range(30, 80);
            end
        end
    end

    // monitor: predicts on input words, checks output words in order
    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            for (int n = 0; n < NODE_COUNT; n++) begin
                mesh_x[n] = '0;
                mesh_y[n] = '0;
                node_volume[n] = '0;
            end
            result_due.delete();
            results_owed <= 0;
            results_seen <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                if (scatter_area(i_word, want)) begin
                    result_due.push_back(want);
                end
            end
            if (o_valid && !i_stall) begin
                got = o_word;
                if (result_due.size() == 0) begin
                    $error("output word with nothing expected: result_kind %0d, value %0d",
                           got.result_kind, got.value);
                    mismatches++;
                end else begin
                    want = result_due.pop_front();
                    report_field("result_kind", CHECK_BITS'(want.result_kind),
                                 CHECK_BITS'(got.result_kind));
                    report_field("out_element", CHECK_BITS'(want.out_element),
                                 CHECK_BITS'(got.out_element));
                    report_field("out_node", CHECK_BITS'(want.out_node),
                                 CHECK_BITS'(got.out_node));
                    report_field("value", CHECK_BITS'(want.value), CHECK_BITS'(got.value));
                    report_field("saturated", CHECK_BITS'(want.saturated),
                                 CHECK_BITS'(got.saturated));
                end
                results_seen <= results_seen + 1;
            end
            results_owed <= result_due.size();
        end
    end

endmodule
